### rtl/lcdq_pkg.sv
// ----------------------------------------------------------------------------
// lcdq_pkg: shared types and constants of the LCD nibble write queue
// Queue geometry, action codes, register map and pointer helpers.
// ----------------------------------------------------------------------------
package lcdq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = PTR_W + 1;

  localparam int ENTRY_W  = 9;
  localparam int GAP_W    = 16;
  localparam int FILL_W   = 6;
  localparam int ACTION_W = 2;
  localparam int NIB_W    = 4;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam int CMD_BIT = 8;

  localparam logic [GAP_W-1:0] CHAR_GAP_RST   = 16'd3;
  localparam logic [GAP_W-1:0] CMD_GAP_RST    = 16'd8;
  localparam logic [GAP_W-1:0] BOOT_DELAY_RST = 16'd50000;
  localparam logic [GAP_W-1:0] INIT_DELAY_RST = 16'd500;

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [GAP_W-1:0]   gap_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_INIT    = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_CHAR_GAP   = 2'd0,
    REG_CMD_GAP    = 2'd1,
    REG_BOOT_DELAY = 2'd2,
    REG_INIT_DELAY = 2'd3
  } reg_index_t;

  typedef struct packed {
    gap_t char_gap;
    gap_t cmd_gap;
    gap_t boot_delay;
    gap_t init_delay;
  } cfg_t;

  // Circular pointer step with wrap at the queue depth.
  function automatic ptr_t next_ptr(input ptr_t p);
    ptr_t r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

  // Entries held between the read and write pointers.
  function automatic cnt_t fill_of(input ptr_t wp, input ptr_t rp);
    cnt_t r;
    if (wp >= rp) begin
      r = {1'b0, wp} - {1'b0, rp};
    end else begin
      r = {1'b0, wp} + CNT_W'(QUEUE_DEPTH) - {1'b0, rp};
    end
    return r;
  endfunction

endpackage

### rtl/lcdq_cfg.sv
// ----------------------------------------------------------------------------
// lcdq_cfg: configuration register file
// Holds the character gap, command gap and delay registers behind an APB port.
// ----------------------------------------------------------------------------
module lcdq_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lcdq_pkg::ADDR_W-1:0]   paddr,
  input  logic [lcdq_pkg::DATA_W-1:0]   pwdata,
  output logic [lcdq_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output lcdq_pkg::cfg_t                cfg
);
  import lcdq_pkg::*;

  reg_index_t idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = reg_index_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.char_gap   <= CHAR_GAP_RST;
      cfg.cmd_gap    <= CMD_GAP_RST;
      cfg.boot_delay <= BOOT_DELAY_RST;
      cfg.init_delay <= INIT_DELAY_RST;
    end else if (wr) begin
      case (idx)
        REG_CHAR_GAP:   cfg.char_gap   <= pwdata[GAP_W-1:0];
        REG_CMD_GAP:    cfg.cmd_gap    <= pwdata[GAP_W-1:0];
        REG_BOOT_DELAY: cfg.boot_delay <= pwdata[GAP_W-1:0];
        REG_INIT_DELAY: cfg.init_delay <= pwdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CHAR_GAP:   prdata = DATA_W'(cfg.char_gap);
      REG_CMD_GAP:    prdata = DATA_W'(cfg.cmd_gap);
      REG_BOOT_DELAY: prdata = DATA_W'(cfg.boot_delay);
      REG_INIT_DELAY: prdata = DATA_W'(cfg.init_delay);
      default:        prdata = '0;
    endcase
  end

endmodule

### rtl/lcdq_store.sv
// ----------------------------------------------------------------------------
// lcdq_store: queue entry memory
// One write port and one registered read port, with a forward of a write
// that lands on the address being read in the same cycle.
// ----------------------------------------------------------------------------
module lcdq_store (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  lcdq_pkg::ptr_t   wr_addr,
  input  lcdq_pkg::entry_t wr_data,
  input  lcdq_pkg::ptr_t   rd_addr,
  output lcdq_pkg::entry_t rd_data
);
  import lcdq_pkg::*;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_q;
  entry_t byp_data;
  logic   byp_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q     <= mem[rd_addr];
    byp_data <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else begin
      byp_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_hit ? byp_data : rd_q;

endmodule

### rtl/char_lcd_queued_nibble_writer.sv
// ----------------------------------------------------------------------------
// char_lcd_queued_nibble_writer: queued 4-bit character LCD write engine
// Enqueues display entries and, on each tick, pops one as two nibbles once
// the skip counter has run down.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock cycle on its input channel unless
// stalled and gives exactly one result transfer for each, via its input and
// result registers. An enqueue action stores a 9-bit entry (bit 8 set marks a
// command) unless the queue already holds depth minus one entries; a tick
// counts the skip counter down or, at zero, pops the oldest entry, if any, and
// presents its high and low nibbles with the register select; init empties
// the queue and loads init_delay into the skip counter. The rate of one item
// per cycle is set by the queue memory, with one write and one registered read
// port: the read port is aimed at the queue head for the next item every
// cycle, so the popped entry is always ready. After reset the skip counter
// holds boot_delay's reset value (50000 ticks). Configuration registers are to
// be written via the APB port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module char_lcd_queued_nibble_writer (
  input  logic                          clk,
  input  logic                          rst,
  // Input channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lcdq_pkg::ACTION_W-1:0] action,
  input  logic [lcdq_pkg::ENTRY_W-1:0]  entry,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          accepted,
  output logic                          send_valid,
  output logic                          reg_select,
  output logic [lcdq_pkg::NIB_W-1:0]    high_nibble,
  output logic [lcdq_pkg::NIB_W-1:0]    low_nibble,
  output logic [lcdq_pkg::FILL_W-1:0]   fill_count,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lcdq_pkg::ADDR_W-1:0]   paddr,
  input  logic [lcdq_pkg::DATA_W-1:0]   pwdata,
  output logic [lcdq_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import lcdq_pkg::*;

  cfg_t cfg;

  // Input register.
  logic                in_q_valid;
  logic [ACTION_W-1:0] action_q;
  entry_t              entry_q;

  // Queue state.
  ptr_t rp;
  ptr_t wp;
  gap_t skip;
  ptr_t rp_next;
  ptr_t wp_next;
  gap_t skip_next;

  entry_t head;
  logic   we;
  logic   fire;
  logic   in_take;
  logic   empty;
  logic   full;
  cnt_t   fill_after;

  logic               accepted_next;
  logic               send_next;
  logic               rs_next;
  logic [NIB_W-1:0]   hi_next;
  logic [NIB_W-1:0]   lo_next;

  lcdq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The read port always looks at the head the next item will see.
  lcdq_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (we),
    .wr_addr (wp),
    .wr_data (entry_q),
    .rd_addr (fire ? rp_next : rp),
    .rd_data (head)
  );

  // The held item executes when the result register is free or being taken.
  assign fire     = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !fire;
  assign in_take  = in_valid && !in_stall;

  assign empty = (wp == rp);
  assign full  = (fill_of(wp, rp) == CNT_W'(QUEUE_DEPTH - 1));

  always_comb begin
    rp_next       = rp;
    wp_next       = wp;
    skip_next     = skip;
    we            = 1'b0;
    accepted_next = 1'b0;
    send_next     = 1'b0;
    rs_next       = 1'b0;
    hi_next       = '0;
    lo_next       = '0;
    case (action_q)
      ACT_ENQUEUE: begin
        if (!full) begin
          we            = fire;
          wp_next       = next_ptr(wp);
          accepted_next = 1'b1;
        end
      end
      ACT_TICK: begin
        if (skip == '0) begin
          skip_next = cfg.char_gap;
          if (!empty) begin
            rp_next   = next_ptr(rp);
            send_next = 1'b1;
            hi_next   = head[2*NIB_W-1:NIB_W];
            lo_next   = head[NIB_W-1:0];
            if (head[CMD_BIT]) begin
              skip_next = cfg.cmd_gap;
            end else begin
              rs_next = 1'b1;
            end
          end
        end else begin
          skip_next = skip - gap_t'(1);
        end
      end
      ACT_INIT: begin
        rp_next   = '0;
        wp_next   = '0;
        skip_next = cfg.init_delay;
      end
      default: ;
    endcase
    fill_after = fill_of(wp_next, rp_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      out_valid  <= 1'b0;
      rp         <= '0;
      wp         <= '0;
      skip       <= BOOT_DELAY_RST;
    end else begin
      if (in_take) begin
        in_q_valid <= 1'b1;
      end else if (fire) begin
        in_q_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
        rp        <= rp_next;
        wp        <= wp_next;
        skip      <= skip_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      action_q <= action;
      entry_q  <= entry;
    end
    if (fire) begin
      accepted    <= accepted_next;
      send_valid  <= send_next;
      reg_select  <= rs_next;
      high_nibble <= hi_next;
      low_nibble  <= lo_next;
      fill_count  <= FILL_W'(fill_after);
    end
  end

endmodule
